/* rtl/hvn_pkg.sv */
package hvn_pkg;

  // Geometry
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CCFG_W   = 11;
  localparam int RCFG_W   = 13;
  localparam int GAIN_W   = 16;
  localparam int H_W      = 8;
  localparam int CFG_W    = 16;

  // Arithmetic widths
  localparam int NORMAL_FRAC_BITS = 15;
  localparam int FACE_W   = 25;
  localparam int SUM_W    = 27;
  localparam int MAG_W    = 26;
  localparam int SS_W     = 54;
  localparam int LEN_W    = SS_W / 2;
  localparam int Q_W      = NORMAL_FRAC_BITS + 1;
  localparam int NUM_W    = MAG_W + NORMAL_FRAC_BITS + 1;
  localparam int ROOT_STEPS = SS_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int DIV_CNT_W  = $clog2(Q_W);
  localparam int XZ_W     = NORMAL_FRAC_BITS + 1;
  localparam int Y_W      = NORMAL_FRAC_BITS;
  localparam int FACE_ONE = 4096;

  typedef enum logic [1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_GAIN = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [FACE_W-1:0] x;
    logic signed [FACE_W-1:0] z;
  } face_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum3_t;

  typedef struct packed {
    logic signed [XZ_W-1:0] x;
    logic [Y_W-1:0]         y;
    logic signed [XZ_W-1:0] z;
  } normal_t;

endpackage

/* rtl/heightmap_vertex_normals_core.sv */
// Heightmap vertex normal generator: one height item in, zero to two normal items out.
// A row-0 item only stores its height and yields no normal; other items go through the face, sum,
// start, calc and emit states, and last-row items run the normal calculation a second time.
// The next item is taken only once the previous one is done, which is set by the
// 27-step square root and 16-step division per normal, plus any output stall.
// Reset (rst, sync, active high) clears counters, neighbor faces, output valid; sets 1024x1024, unity gain.
module heightmap_vertex_normals_core import hvn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // Input stream; tdata fields from bit 0: height[7:0].
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  // Output stream; tdata fields from bit 0: vertex_row[11:0], vertex_col[21:12],
  // normal_x[37:22], normal_y[52:38], normal_z[68:53], zero padding [71:69].
  // tlast carries last_of_run.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [71:0]      m_tdata,
  output logic             m_tlast
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FACE  = 6'b000010,
    S_SUM   = 6'b000100,
    S_START = 6'b001000,
    S_CALC  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers and their clamped views.
  logic [CCFG_W-1:0] grid_cols;
  logic [RCFG_W-1:0] grid_rows;
  logic [GAIN_W-1:0] height_gain;
  logic [CCFG_W-1:0] cols_eff;
  logic [RCFG_W-1:0] rows_eff;

  // Raster position of the next item.
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  // Snapshot of the item being worked on.
  logic [H_W-1:0]   h_reg;
  logic [ROW_W-1:0] r_reg;
  logic [COL_W-1:0] c_reg;
  logic             right;
  logic             left;
  logic             upper;
  logic             lastrow;
  logic             row_nz;
  logic             second;

  logic             accept;
  logic [H_W-1:0]   rd_h0;
  logic [H_W-1:0]   rd_h1;
  face_t            up;
  face_t            cur;
  face_t            lf0;
  face_t            lf1;
  sum3_t            sum1;
  sum3_t            sum2;
  sum3_t            norm_in;
  logic             norm_done;
  normal_t          norm_res;

  logic signed [H_W:0]         dx;
  logic signed [H_W:0]         dz;
  logic signed [GAIN_W+H_W:0]  px;
  logic signed [GAIN_W+H_W:0]  pz;

  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  normal_t          out_n;
  logic             out_valid;
  logic             out_last;
  logic             out_load;

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(FACE_ONE);

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [FACE_W-1:0] v);
    ext = {{(SUM_W-FACE_W){v[FACE_W-1]}}, v};
  endfunction

  assign cols_eff = (grid_cols < CCFG_W'(2)) ? CCFG_W'(2) :
                    (grid_cols > CCFG_W'(MAX_COLS)) ? CCFG_W'(MAX_COLS) : grid_cols;
  assign rows_eff = (grid_rows < RCFG_W'(2)) ? RCFG_W'(2) :
                    (grid_rows > RCFG_W'(MAX_ROWS)) ? RCFG_W'(MAX_ROWS) : grid_rows;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // The output register takes a new normal once it is empty or being drained.
  assign out_load = (state == S_EMIT) && (!out_valid || m_tready);

  // Configuration writes; only taken while idle by contract.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols   <= CCFG_W'(1024);
      grid_rows   <= RCFG_W'(1024);
      height_gain <= GAIN_W'(4096);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: grid_cols   <= cfg_data[CCFG_W-1:0];
        CFG_ROWS: grid_rows   <= cfg_data[RCFG_W-1:0];
        CFG_GAIN: height_gain <= cfg_data;
        default:  ;
      endcase
    end
  end

  // The memories are read only when an item is accepted, so their outputs
  // stay put while the item is worked on and its writes land.
  hvn_lines u_lines (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .wr_addr (c_reg),
    .we_h    (state == S_FACE),
    .wr_h    (h_reg),
    .we_f    ((state == S_SUM) && right),
    .wr_f    (cur),
    .rd_h0   (rd_h0),
    .rd_h1   (rd_h1),
    .rd_f    (up)
  );

  // Face of the cell above-right of this item: gain times the height steps.
  assign dx = $signed({1'b0, rd_h0}) - $signed({1'b0, rd_h1});
  assign dz = $signed({1'b0, rd_h0}) - $signed({1'b0, h_reg});
  assign px = $signed({1'b0, height_gain}) * dx;
  assign pz = $signed({1'b0, height_gain}) * dz;

  assign norm_in = second ? sum2 : sum1;

  hvn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .sum   (norm_in),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      col_count <= '0;
      lf0       <= '0;
      lf1       <= '0;
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            h_reg   <= s_tdata[H_W-1:0];
            r_reg   <= row_count;
            c_reg   <= col_count;
            right   <= (CCFG_W'(col_count) + CCFG_W'(1)) < cols_eff;
            left    <= col_count != '0;
            upper   <= row_count >= ROW_W'(2);
            row_nz  <= row_count != '0;
            lastrow <= (RCFG_W'(row_count) + RCFG_W'(1)) >= rows_eff;
            // Advance the raster position; wrap at the end of a row and a frame.
            if ((CCFG_W'(col_count) + CCFG_W'(1)) >= cols_eff) begin
              col_count <= '0;
              if ((RCFG_W'(row_count) + RCFG_W'(1)) >= rows_eff) begin
                row_count <= '0;
              end else begin
                row_count <= row_count + ROW_W'(1);
              end
            end else begin
              col_count <= col_count + COL_W'(1);
            end
            state <= S_FACE;
          end
        end
        S_FACE: begin
          // A column with nothing to its right has no face.
          cur.x <= right ? px[FACE_W-1:0] : '0;
          cur.z <= right ? pz[FACE_W-1:0] : '0;
          state <= row_nz ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          // Upper vertex: up to four faces. Last-row vertex: the two below-row faces.
          sum1.x <= ((upper && left) ? ext(lf1.x) : '0) + ((upper && right) ? ext(up.x) : '0)
                  + (left ? ext(lf0.x) : '0) + (right ? ext(cur.x) : '0);
          sum1.z <= ((upper && left) ? ext(lf1.z) : '0) + ((upper && right) ? ext(up.z) : '0)
                  + (left ? ext(lf0.z) : '0) + (right ? ext(cur.z) : '0);
          sum1.y <= ((upper && left) ? ONE_S : '0) + ((upper && right) ? ONE_S : '0)
                  + (left ? ONE_S : '0) + (right ? ONE_S : '0);
          sum2.x <= (left ? ext(lf0.x) : '0) + (right ? ext(cur.x) : '0);
          sum2.z <= (left ? ext(lf0.z) : '0) + (right ? ext(cur.z) : '0);
          sum2.y <= (left ? ONE_S : '0) + (right ? ONE_S : '0);
          lf1 <= up;
          if (right) begin
            lf0 <= cur;
          end
          second <= 1'b0;
          state  <= S_START;
        end
        S_START: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (norm_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Load the output register once it is empty or being drained.
          if (out_load) begin
            out_row   <= second ? r_reg : r_reg - ROW_W'(1);
            out_col   <= c_reg;
            out_n     <= norm_res;
            out_last  <= second || !lastrow;
            if (!second && lastrow) begin
              second <= 1'b1;
              state  <= S_START;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_n.z, out_n.y, out_n.x, out_col, out_row};

endmodule

/* rtl/hvn_lines.sv */
module hvn_lines import hvn_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic [COL_W-1:0] wr_addr,
  input  logic             we_h,
  input  logic [H_W-1:0]   wr_h,
  input  logic             we_f,
  input  face_t            wr_f,
  output logic [H_W-1:0]   rd_h0,
  output logic [H_W-1:0]   rd_h1,
  output face_t            rd_f
);

  logic [H_W-1:0] height_mem [MAX_COLS];
  face_t          face_mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (we_h) begin
      height_mem[wr_addr] <= wr_h;
    end
    if (rd_en) begin
      rd_h0 <= height_mem[rd_addr];
      rd_h1 <= height_mem[rd_addr + COL_W'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (we_f) begin
      face_mem[wr_addr] <= wr_f;
    end
    if (rd_en) begin
      rd_f <= face_mem[rd_addr];
    end
  end

endmodule

/* rtl/hvn_isqrt.sv */
module hvn_isqrt import hvn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SS_W-1:0]  n,
  output logic             done,
  output logic [LEN_W-1:0] root
);

  logic [SS_W-1:0]       num;
  logic [LEN_W+1:0]      rem;
  logic [ROOT_CNT_W-1:0] cnt;
  logic                  busy;
  logic [LEN_W+3:0]      shifted;
  logic [LEN_W+3:0]      trial;
  logic [LEN_W+3:0]      diff;
  logic                  ge;

  // One result bit per cycle, two radicand bits consumed each step.
  assign shifted = {rem, num[SS_W-1:SS_W-2]};
  assign trial   = {2'b00, root, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= n;
        rem  <= '0;
        root <= '0;
        cnt  <= ROOT_CNT_W'(ROOT_STEPS - 1);
      end else if (busy) begin
        num  <= {num[SS_W-3:0], 2'b00};
        rem  <= ge ? diff[LEN_W+1:0] : shifted[LEN_W+1:0];
        root <= {root[LEN_W-2:0], ge};
        cnt  <= cnt - ROOT_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/hvn_div.sv */
module hvn_div import hvn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [LEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [LEN_W:0]       sh;
  logic [LEN_W:0]       diff;
  logic                 ge;

  // The quotient is known to fit in Q_W bits, so the upper dividend bits
  // preload the remainder and only Q_W restoring steps are needed.
  assign sh   = {rem, quo[Q_W-1]};
  assign diff = sh - {1'b0, dvs};
  assign ge   = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= LEN_W'(num[NUM_W-1:Q_W]);
        quo  <= num[Q_W-1:0];
        dvs  <= den;
        cnt  <= DIV_CNT_W'(Q_W - 1);
      end else if (busy) begin
        rem <= ge ? diff[LEN_W-1:0] : sh[LEN_W-1:0];
        quo <= {quo[Q_W-2:0], ge};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/hvn_norm.sv */
module hvn_norm import hvn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sum3_t   sum,
  output logic    done,
  output normal_t res
);

  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_SQ   = 5'b00010,
    N_ROOT = 5'b00100,
    N_DIV  = 5'b01000,
    N_FIN  = 5'b10000
  } nstate_t;

  localparam logic [Y_W-1:0] LIM = {Y_W{1'b1}};

  nstate_t            state;
  logic [MAG_W-1:0]   mag [3];
  logic               neg [3];
  logic [1:0]         sq_cnt;
  logic [2*MAG_W-1:0] prod;
  logic [SS_W-1:0]    acc;
  logic               root_start;
  logic               root_done;
  logic [LEN_W-1:0]   root;
  logic [LEN_W-1:0]   len;
  logic               div_start;
  logic               div_done [3];
  logic [Q_W-1:0]     quo [3];
  logic [Y_W-1:0]     sat [3];
  logic [MAG_W-1:0]   sq_sel;
  logic signed [SUM_W-1:0] comp_in [3];

  assign comp_in[0] = sum.x;
  assign comp_in[1] = sum.y;
  assign comp_in[2] = sum.z;

  always_comb begin
    case (sq_cnt)
      2'd0:    sq_sel = mag[0];
      2'd1:    sq_sel = mag[1];
      default: sq_sel = mag[2];
    endcase
  end

  hvn_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .n     (acc),
    .done  (root_done),
    .root  (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [NUM_W-1:0] dnum;
    assign dnum = NUM_W'({mag[i], {NORMAL_FRAC_BITS{1'b0}}}) + NUM_W'(len >> 1);

    hvn_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (dnum),
      .den   (len),
      .done  (div_done[i]),
      .quo   (quo[i])
    );

    // Zero length leaves all components at zero.
    assign sat[i] = (len == '0) ? '0 :
                    (quo[i] > Q_W'(LIM)) ? LIM : quo[i][Y_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= N_IDLE;
      done       <= 1'b0;
      root_start <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      done       <= 1'b0;
      root_start <= 1'b0;
      div_start  <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= comp_in[i][SUM_W-1];
              mag[i] <= comp_in[i][SUM_W-1] ? MAG_W'(-comp_in[i]) : MAG_W'(comp_in[i]);
            end
            acc    <= '0;
            sq_cnt <= 2'd0;
            state  <= N_SQ;
          end
        end
        N_SQ: begin
          // One shared multiplier squares one component per cycle.
          if (sq_cnt != 2'd3) begin
            prod <= sq_sel * sq_sel;
          end
          if (sq_cnt != 2'd0) begin
            acc <= acc + SS_W'(prod);
          end
          sq_cnt <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd3) begin
            root_start <= 1'b1;
            state      <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (root_done) begin
            len       <= root;
            div_start <= 1'b1;
            state     <= N_DIV;
          end
        end
        N_DIV: begin
          if (div_done[0]) begin
            state <= N_FIN;
          end
        end
        N_FIN: begin
          res.x <= neg[0] ? -$signed({1'b0, sat[0]}) : $signed({1'b0, sat[0]});
          res.y <= sat[1];
          res.z <= neg[2] ? -$signed({1'b0, sat[2]}) : $signed({1'b0, sat[2]});
          done  <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

/* rtl/hvn_checker.sv */
module hvn_checker import hvn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  // Padding above the last field is always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:69] == 3'b000)
    else $error("output padding not zero");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // One item is worked on at a time: input is closed right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

endmodule

bind heightmap_vertex_normals_core hvn_checker u_hvn_checker (.*);
